// ===== src/zvpc_pkg.sv =====
// Package for the zoomed viewport controller: constants, opcodes and register indexes.
package zvpc_pkg;

  localparam int unsigned CoordBitsDefault = 13;
  localparam int unsigned ZoomFracDefault  = 10;

  localparam int unsigned ZoomW  = 14;
  localparam int unsigned PointW = 14;
  localparam int unsigned SpanW  = 15;
  localparam int unsigned MapW   = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [2:0] OpEnable  = 3'd0;
  localparam logic [2:0] OpPinch   = 3'd1;
  localparam logic [2:0] OpPan     = 3'd2;
  localparam logic [2:0] OpConvert = 3'd3;
  localparam logic [2:0] OpTap     = 3'd4;

  localparam logic [CfgIdxW-1:0] RegScreenW  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegScreenH  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDiagonal = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinZoom  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxZoom  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStartZoom = 3'd5;
  localparam logic [CfgIdxW-1:0] RegHotBand  = 3'd6;

  localparam logic [1:0] AreaNone   = 2'd0;
  localparam logic [1:0] AreaBottom = 2'd1;
  localparam logic [1:0] AreaLeft   = 2'd2;
  localparam logic [1:0] AreaRight  = 2'd3;

  localparam logic [13:0] ResetStartZoom = 14'd2048;

endpackage

// ===== src/zvpc_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface zvpc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic signed [13:0] point_x;
  logic signed [13:0] point_y;
  logic signed [14:0] pinch_span;
  modport source (output valid, operation, point_x, point_y, pinch_span, input ready);
  modport sink (input valid, operation, point_x, point_y, pinch_span, output ready);
endinterface

interface zvpc_res_if #(parameter int unsigned CoordBits = 13);
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] view_x;
  logic [CoordBits-1:0] view_y;
  logic [CoordBits-1:0] view_width;
  logic [CoordBits-1:0] view_height;
  logic [13:0]          zoom;
  logic signed [14:0]   mapped_x;
  logic signed [14:0]   mapped_y;
  logic [1:0]           hot_area;
  logic                 rejected;
  modport source (output valid, view_x, view_y, view_width, view_height, zoom,
                  mapped_x, mapped_y, hot_area, rejected, input ready);
  modport sink (input valid, view_x, view_y, view_width, view_height, zoom,
                mapped_x, mapped_y, hot_area, rejected, output ready);
endinterface

// ===== src/zoom_viewport_pan_clamp.sv =====
// Top level of the zoomed viewport controller with pan, pinch and clamping.
//
//   channel   | dir | handshake
//   req_if    | in  | valid/ready, one request per step
//   res_if    | out | valid/ready, one result per request
//   cfg_*     | in  | write enable, index, data; no stall
//
// A request is latched at its accepting edge. Each pass through the shared
// restoring divider holds the sequencer until the divider reports done.
// Enable divides for the window width and height, then places the window;
// pinch multiplies, divides and clamps the zoom first. Convert divides for
// both pointer axes. Pan, tap, unknown operations and refused pinches skip
// the divider. Reset clears the window and loads the start zoom. The request
// side is not ready while a step runs or a result waits to be taken.
module zoom_viewport_pan_clamp #(
  parameter int unsigned CoordBits = zvpc_pkg::CoordBitsDefault,
  parameter int unsigned ZoomFrac  = zvpc_pkg::ZoomFracDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [zvpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [zvpc_pkg::CfgDataW-1:0] cfg_data_i,
  zvpc_req_if.sink   req_if,
  zvpc_res_if.source res_if
);
  import zvpc_pkg::*;

  // The divider must hold the pinch product magnitude as well as the scaled
  // screen sizes and pointer magnitudes.
  localparam int unsigned ProdMagW = ZoomW + SpanW - 1;
  localparam int unsigned ScaledW = ((CoordBits > PointW) ? CoordBits : PointW) + ZoomFrac + 1;
  localparam int unsigned NumW = (ProdMagW > ScaledW) ? ProdMagW : ScaledW;
  localparam int unsigned WideW = NumW + 4;
  localparam int unsigned SumW = CoordBits + 4;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDivW   = 4'd1;
  localparam logic [3:0] StDivH   = 4'd2;
  localparam logic [3:0] StPlace  = 4'd3;
  localparam logic [3:0] StMul    = 4'd4;
  localparam logic [3:0] StDivZ   = 4'd5;
  localparam logic [3:0] StClampZ = 4'd6;
  localparam logic [3:0] StConvX  = 4'd7;
  localparam logic [3:0] StConvY  = 4'd8;
  localparam logic [3:0] StAnchor = 4'd9;
  localparam logic [3:0] StOut    = 4'd10;

  logic [3:0] st_q, st_d;
  logic       dwait_q, dwait_d;

  logic [CoordBits-1:0] scr_w_q, scr_h_q, band_q;
  logic [13:0] diag_q, minz_q, maxz_q;

  logic [CoordBits-1:0] sx_q, sx_d, sy_q, sy_d, sw_q, sw_d, sh_q, sh_d;
  logic [CoordBits-1:0] ax_q, ax_d, ay_q, ay_d;
  logic [ZoomW-1:0] zoom_q, zoom_d;

  logic [2:0] op_q, op_d;
  logic signed [PointW-1:0] px_q, px_d, py_q, py_d;
  logic signed [SpanW-1:0] span_q, span_d;
  logic signed [29:0] prod_q, prod_d;

  logic [CoordBits-1:0] ovx_q, ovx_d, ovy_q, ovy_d, ovw_q, ovw_d, ovh_q, ovh_d;
  logic [ZoomW-1:0] oz_q, oz_d;
  logic signed [MapW-1:0] omx_q, omx_d, omy_q, omy_d;
  logic [1:0] oarea_q, oarea_d;
  logic orej_q, orej_d;
  logic ovalid_q, ovalid_d;

  logic div_start;
  logic [NumW-1:0] div_num;
  logic [15:0] div_den;
  logic div_done;
  logic [NumW-1:0] div_quot;

  zvpc_div #(.NumW(NumW), .DenW(16)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= CoordBits'(1920);
      scr_h_q  <= CoordBits'(1080);
      diag_q   <= 14'd2203;
      minz_q   <= 14'd1024;
      maxz_q   <= 14'd5120;
      band_q   <= CoordBits'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegScreenW:   scr_w_q  <= CoordBits'(cfg_data_i[12:0]);
        RegScreenH:   scr_h_q  <= CoordBits'(cfg_data_i[12:0]);
        RegDiagonal:  diag_q   <= cfg_data_i;
        RegMinZoom:   minz_q   <= cfg_data_i;
        RegMaxZoom:   maxz_q   <= cfg_data_i;
        // A write to the start zoom is dropped, and reset always loads the constant
        // ResetStartZoom, so such a write is never seen.
        RegStartZoom: ;
        RegHotBand:   band_q   <= CoordBits'(cfg_data_i[12:0]);
        default: ;
      endcase
    end
  end

  // Helpers that clamp and saturate wide values.
  function automatic logic [CoordBits-1:0] clamp_pos(input logic signed [SumW-1:0] p,
                                                      input logic [CoordBits-1:0] sz,
                                                      input logic [CoordBits-1:0] scr);
    logic signed [SumW-1:0] lim;
    logic signed [SumW-1:0] r;
    lim = $signed({4'd0, scr}) - $signed({4'd0, sz});
    r = p;
    if (r < 0) r = '0;
    if (r > lim) r = lim;
    if (r < 0) r = '0;
    return r[CoordBits-1:0];
  endfunction

  function automatic logic signed [MapW-1:0] sat15(input logic signed [WideW-1:0] v);
    if (v > WideW'(16383)) return 15'sd16383;
    if (v < -$signed(WideW'(16384))) return -15'sd16384;
    return v[MapW-1:0];
  endfunction

  function automatic logic [CoordBits-1:0] satsize(input logic [NumW-1:0] q,
                                                   input logic [CoordBits-1:0] scr);
    if (q > NumW'(scr)) return scr;
    return q[CoordBits-1:0];
  endfunction

  logic signed [PointW-1:0] conv_pt;
  logic conv_neg;
  logic [PointW-1:0] conv_mag;
  logic signed [SumW-1:0] ctr_x, ctr_y;
  logic [NumW-1:0] qmag;
  logic signed [WideW-1:0] qs;
  logic [29:0] prod_mag;
  logic signed [WideW-1:0] ztmp;
  logic signed [SumW-1:0] h_s, w_s, b_s, pxs, pys;

  always_comb begin
    st_d = st_q; dwait_d = 1'b0;
    sx_d = sx_q; sy_d = sy_q; sw_d = sw_q; sh_d = sh_q;
    ax_d = ax_q; ay_d = ay_q; zoom_d = zoom_q;
    op_d = op_q; px_d = px_q; py_d = py_q; span_d = span_q; prod_d = prod_q;
    ovx_d = ovx_q; ovy_d = ovy_q; ovw_d = ovw_q; ovh_d = ovh_q; oz_d = oz_q;
    omx_d = omx_q; omy_d = omy_q; oarea_d = oarea_q; orej_d = orej_q;
    ovalid_d = ovalid_q;
    div_start = 1'b0; div_num = '0; div_den = '0;
    conv_pt = (st_q == StConvX) ? px_q : py_q;
    conv_neg = conv_pt[PointW-1];
    conv_mag = conv_neg ? PointW'(-conv_pt) : PointW'(conv_pt);
    ctr_x = (op_q == OpEnable) ? SumW'(px_q) : $signed({4'd0, ax_q});
    ctr_y = (op_q == OpEnable) ? SumW'(py_q) : $signed({4'd0, ay_q});
    prod_mag = prod_q[29] ? 30'(-prod_q) : 30'(prod_q);
    qmag = div_quot;
    qs = '0;
    ztmp = '0;
    h_s = $signed({4'd0, scr_h_q});
    w_s = $signed({4'd0, scr_w_q});
    b_s = $signed({4'd0, band_q});
    pxs = SumW'(px_q);
    pys = SumW'(py_q);

    if (res_if.ready) ovalid_d = 1'b0;

    case (st_q)
      StIdle: begin
        if (req_if.valid && !ovalid_q) begin
          op_d = req_if.operation; px_d = req_if.point_x; py_d = req_if.point_y;
          span_d = req_if.pinch_span;
          omx_d = '0; omy_d = '0; oarea_d = AreaNone; orej_d = 1'b0;
          case (req_if.operation)
            OpEnable: st_d = StDivW;
            OpPinch: begin
              if (scr_w_q == '0 || scr_h_q == '0 || diag_q == '0) begin
                orej_d = 1'b1; st_d = StOut;
              end else st_d = StMul;
            end
            OpPan: begin
              sx_d = clamp_pos($signed({4'd0, sx_q}) - SumW'(req_if.point_x), sw_q, scr_w_q);
              sy_d = clamp_pos($signed({4'd0, sy_q}) - SumW'(req_if.point_y), sh_q, scr_h_q);
              st_d = StAnchor;
            end
            OpConvert: st_d = (zoom_q == '0) ? StOut : StConvX;
            OpTap: st_d = StPlace;
            default: st_d = StOut;
          endcase
        end
      end
      StMul: begin
        prod_d = $signed({1'b0, zoom_q}) * span_q;
        st_d = StDivZ;
      end
      StDivZ: begin
        if (!dwait_q) begin
          div_start = 1'b1; div_num = NumW'(prod_mag); div_den = 16'(diag_q);
          dwait_d = 1'b1;
        end else if (div_done) begin
          st_d = StClampZ;
        end else dwait_d = 1'b1;
      end
      StClampZ: begin
        qs = prod_q[29] ? -$signed({4'd0, qmag}) : $signed({4'd0, qmag});
        ztmp = $signed(WideW'(zoom_q)) + qs;
        if (ztmp > $signed(WideW'(maxz_q))) ztmp = $signed(WideW'(maxz_q));
        if (ztmp < $signed(WideW'(minz_q))) ztmp = $signed(WideW'(minz_q));
        zoom_d = ztmp[ZoomW-1:0];
        st_d = StDivW;
      end
      StDivW, StDivH: begin
        if (zoom_q == '0) begin
          sw_d = scr_w_q; sh_d = scr_h_q; st_d = StPlace;
        end else if (!dwait_q) begin
          div_start = 1'b1;
          div_num = NumW'({(st_q == StDivW) ? scr_w_q : scr_h_q, ZoomFrac'(0)});
          div_den = 16'(zoom_q);
          dwait_d = 1'b1;
        end else if (div_done) begin
          if (st_q == StDivW) begin
            sw_d = satsize(qmag, scr_w_q); st_d = StDivH;
          end else begin
            sh_d = satsize(qmag, scr_h_q); st_d = StPlace;
          end
        end else dwait_d = 1'b1;
      end
      StPlace: begin
        if (op_q == OpTap) begin
          omx_d = MapW'(px_q); omy_d = MapW'(py_q);
          if (pys <= h_s && pys >= h_s - b_s) begin
            oarea_d = AreaBottom;
            omy_d = sat15(WideW'(pys + h_s - $signed({4'd0, sy_q}) - $signed({4'd0, sh_q})));
          end else if (pxs >= 0 && pxs <= b_s) begin
            oarea_d = AreaLeft;
            omx_d = sat15(WideW'(pxs - $signed({4'd0, sx_q})));
          end else if (pxs >= w_s - b_s && pxs <= w_s) begin
            oarea_d = AreaRight;
            omx_d = sat15(WideW'(pxs + w_s - $signed({4'd0, sx_q}) - $signed({4'd0, sw_q})));
          end
          st_d = StOut;
        end else begin
          sx_d = clamp_pos(ctr_x - $signed({4'd0, sw_q >> 1}), sw_q, scr_w_q);
          sy_d = clamp_pos(ctr_y - $signed({4'd0, sh_q >> 1}), sh_q, scr_h_q);
          st_d = StAnchor;
        end
      end
      StConvX, StConvY: begin
        if (!dwait_q) begin
          div_start = 1'b1;
          div_num = NumW'({conv_mag, ZoomFrac'(0)});
          div_den = 16'(zoom_q);
          dwait_d = 1'b1;
        end else if (div_done) begin
          qs = conv_neg ? -$signed({4'd0, qmag}) : $signed({4'd0, qmag});
          if (st_q == StConvX) begin
            omx_d = sat15($signed(WideW'(sx_q)) + qs); st_d = StConvY;
          end else begin
            omy_d = sat15($signed(WideW'(sy_q)) + qs); st_d = StOut;
          end
        end else dwait_d = 1'b1;
      end
      StAnchor: begin
        ax_d = sx_q + (sw_q >> 1);
        ay_d = sy_q + (sh_q >> 1);
        st_d = StOut;
      end
      StOut: begin
        ovx_d = sx_q; ovy_d = sy_q; ovw_d = sw_q; ovh_d = sh_q; oz_d = zoom_q;
        ovalid_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; dwait_q <= 1'b0; ovalid_q <= 1'b0;
      sx_q <= '0; sy_q <= '0; sw_q <= '0; sh_q <= '0; ax_q <= '0; ay_q <= '0;
      zoom_q <= ResetStartZoom;
    end else begin
      st_q <= st_d; dwait_q <= dwait_d; ovalid_q <= ovalid_d;
      sx_q <= sx_d; sy_q <= sy_d; sw_q <= sw_d; sh_q <= sh_d;
      ax_q <= ax_d; ay_q <= ay_d; zoom_q <= zoom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; px_q <= px_d; py_q <= py_d; span_q <= span_d; prod_q <= prod_d;
    ovx_q <= ovx_d; ovy_q <= ovy_d; ovw_q <= ovw_d; ovh_q <= ovh_d; oz_q <= oz_d;
    omx_q <= omx_d; omy_q <= omy_d; oarea_q <= oarea_d; orej_q <= orej_d;
  end

  assign req_if.ready = (st_q == StIdle) && !ovalid_q;
  assign res_if.valid = ovalid_q;
  assign res_if.view_x = ovx_q;
  assign res_if.view_y = ovy_q;
  assign res_if.view_width = ovw_q;
  assign res_if.view_height = ovh_q;
  assign res_if.zoom = oz_q;
  assign res_if.mapped_x = omx_q;
  assign res_if.mapped_y = omy_q;
  assign res_if.hot_area = oarea_q;
  assign res_if.rejected = orej_q;

`ifndef SYNTHESIS
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !req_if.ready) else $error("request taken while busy");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && !res_if.ready) |=> res_if.valid) else $error("result dropped");
  a_rej_only_pinch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.rejected |-> (op_q == OpPinch)) else $error("reject outside pinch");
  a_zoom_pinch_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zoom_q != $past(zoom_q)) |-> ($past(st_q) == StClampZ)) else $error("zoom changed");
`endif
endmodule

// ===== src/zvpc_div.sv =====
// Shared restoring divider: unsigned quotient, one bit per cycle.
module zvpc_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = diff;
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !start_i) |=> !busy_q) else $error("divider started without request");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
`endif
endmodule
